/* src/gfte_pkg.sv */
package gfte_pkg;

  localparam int GATE_W     = 11;
  localparam int SAMPLE_W   = 16;
  localparam int OP_W       = 4;
  localparam int CMP_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_GATES_DEF = 2048;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SET   = 4'd0;
  localparam logic [OP_W-1:0] OP_AND   = 4'd1;
  localparam logic [OP_W-1:0] OP_OR    = 4'd2;
  localparam logic [OP_W-1:0] OP_XOR   = 4'd3;
  localparam logic [OP_W-1:0] OP_COPY  = 4'd4;
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd5;
  localparam logic [OP_W-1:0] OP_COMPL = 4'd6;
  localparam logic [OP_W-1:0] OP_ASSRT = 4'd7;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd8;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd9;

  // Compare modes
  localparam logic [CMP_W-1:0] CMP_BELOW   = 2'd0;
  localparam logic [CMP_W-1:0] CMP_ABOVE   = 2'd1;
  localparam logic [CMP_W-1:0] CMP_BETWEEN = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMP_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_AMT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MUL_AMT   = 3'd6;

  localparam logic [SAMPLE_W-1:0] MISSING_RST = 16'h8000;
  localparam logic [SAMPLE_W-1:0] MUL_AMT_RST = 16'h0001;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [CMP_W-1:0]    compare_mode;
    logic [SAMPLE_W-1:0] threshold_low;
    logic [SAMPLE_W-1:0] threshold_high;
    logic [SAMPLE_W-1:0] missing_code;
    logic [SAMPLE_W-1:0] add_amount;
    logic [SAMPLE_W-1:0] mul_amount;
  } cfg_t;

endpackage

/* src/gfte_if.sv */
interface gfte_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [gfte_pkg::GATE_W-1:0]           gate;
  logic signed [gfte_pkg::SAMPLE_W-1:0]  sample;
  logic                                  in_boundary;

  modport source (output valid, gate, sample, in_boundary, input ready);
  modport sink   (input valid, gate, sample, in_boundary, output ready);
endinterface

interface gfte_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [gfte_pkg::GATE_W-1:0]           gate_out;
  logic signed [gfte_pkg::SAMPLE_W-1:0]  sample_out;
  logic                                  flag_out;

  modport source (output valid, gate_out, sample_out, flag_out, input ready);
  modport sink   (input valid, gate_out, sample_out, flag_out, output ready);
endinterface

/* src/gfte_ram.sv */
module gfte_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/gfte_cfg.sv */
module gfte_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gfte_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gfte_pkg::CFG_DATA_W-1:0]    cfg_data,
  output gfte_pkg::cfg_t                     cfg
);

  gfte_pkg::cfg_t cfg_r;
  gfte_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        gfte_pkg::REG_OPERATION: cfg_nxt.operation      = cfg_data[gfte_pkg::OP_W-1:0];
        gfte_pkg::REG_CMP_MODE:  cfg_nxt.compare_mode   = cfg_data[gfte_pkg::CMP_W-1:0];
        gfte_pkg::REG_THR_LOW:   cfg_nxt.threshold_low  = cfg_data;
        gfte_pkg::REG_THR_HIGH:  cfg_nxt.threshold_high = cfg_data;
        gfte_pkg::REG_MISSING:   cfg_nxt.missing_code   = cfg_data;
        gfte_pkg::REG_ADD_AMT:   cfg_nxt.add_amount     = cfg_data;
        gfte_pkg::REG_MUL_AMT:   cfg_nxt.mul_amount     = cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.operation      <= gfte_pkg::OP_SET;
      cfg_r.compare_mode   <= gfte_pkg::CMP_BELOW;
      cfg_r.threshold_low  <= '0;
      cfg_r.threshold_high <= '0;
      cfg_r.missing_code   <= gfte_pkg::MISSING_RST;
      cfg_r.add_amount     <= '0;
      cfg_r.mul_amount     <= gfte_pkg::MUL_AMT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/gfte_edit.sv */
module gfte_edit (
  input  gfte_pkg::cfg_t                  cfg,
  input  logic [gfte_pkg::SAMPLE_W-1:0]   sample,
  input  logic                            bnd,
  input  logic                            miss,
  input  logic                            thr,
  input  logic                            flag_old,
  output logic [gfte_pkg::SAMPLE_W-1:0]   sample_new,
  output logic                            flag_new
);

  logic [2*gfte_pkg::SAMPLE_W-1:0] prod;
  logic [gfte_pkg::SAMPLE_W-1:0]   sum;
  logic                            edit_ok;

  // low half of the product is the same for signed and unsigned operands
  assign prod    = (2*gfte_pkg::SAMPLE_W)'(sample) * (2*gfte_pkg::SAMPLE_W)'(cfg.mul_amount);
  assign sum     = sample + cfg.add_amount;
  assign edit_ok = bnd & flag_old & ~miss;

  always_comb begin
    flag_new   = flag_old;
    sample_new = sample;
    unique case (cfg.operation)
      gfte_pkg::OP_SET:   flag_new = bnd & ~miss & thr;
      gfte_pkg::OP_AND:   if (bnd) flag_new = ~miss & flag_old & thr;
      gfte_pkg::OP_OR:    if (bnd & ~miss) flag_new = flag_old | thr;
      gfte_pkg::OP_XOR:   if (bnd & ~miss) flag_new = flag_old ^ thr;
      gfte_pkg::OP_COPY:  if (bnd) flag_new = miss;
      gfte_pkg::OP_CLEAR: flag_new = 1'b0;
      gfte_pkg::OP_COMPL: flag_new = ~flag_old;
      gfte_pkg::OP_ASSRT: if (bnd & flag_old) sample_new = cfg.missing_code;
      gfte_pkg::OP_ADD:   if (edit_ok) sample_new = sum;
      gfte_pkg::OP_MUL:   if (edit_ok) sample_new = prod[gfte_pkg::SAMPLE_W-1:0];
      default: ;  // unused codes pass the item through
    endcase
  end

endmodule

/* src/gate_flag_threshold_editor_core.sv */
// Per-gate flag editor: one flag bit per range gate lives in a single-port-read,
// single-port-write RAM. Each item reads its gate's flag, the next stage applies
// the configured operation and writes the flag back, and the result leaves from an
// output register, so an item is taken every cycle unless the output stalls or the
// flag clear runs; a result passes stage 1 and the output register before it is
// offered, and a write to the gate being read on the same edge is forwarded.
// After reset the block sweeps the flag RAM to zero, one gate a cycle, and takes no
// item until the sweep ends; configuration writes are taken throughout. Gates at or
// above NUM_GATES read a flag of zero and do not write.
module gate_flag_threshold_editor_core #(
  parameter int NUM_GATES = gfte_pkg::NUM_GATES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  gfte_in_if.sink                          in_ch,
  gfte_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [gfte_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gfte_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(NUM_GATES);
  localparam int SW = gfte_pkg::SAMPLE_W;
  localparam int GW = gfte_pkg::GATE_W;

  gfte_pkg::cfg_t cfg;

  gfte_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // clearing sweep
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // stage 1: item waiting on its flag
  logic          s1_valid_r;
  logic [GW-1:0] s1_gate_r;
  logic [SW-1:0] s1_sample_r;
  logic          s1_bnd_r;
  logic          s1_ok_r;
  logic          s1_miss_r;
  logic          s1_thr_r;
  logic [AW-1:0] s1_addr_r;
  logic          fwd_hit_r;
  logic          fwd_val_r;

  // output register
  logic          out_valid_r;
  logic [GW-1:0] out_gate_r;
  logic [SW-1:0] out_sample_r;
  logic          out_flag_r;

  logic          acc_in;
  logic          s1_adv;
  logic          gate_ok;
  logic          miss;
  logic          thr;
  logic [AW-1:0] raddr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;
  logic          flag_old;
  logic          flag_new;
  logic [SW-1:0] sample_new;

  assign s1_adv      = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~clr_busy_r & (~s1_valid_r | s1_adv);
  assign acc_in      = in_ch.valid & in_ch.ready;

  assign gate_ok = 32'(in_ch.gate) < 32'(NUM_GATES);
  assign raddr   = AW'(in_ch.gate);
  assign miss    = in_ch.sample == $signed(cfg.missing_code);

  always_comb begin
    unique case (cfg.compare_mode)
      gfte_pkg::CMP_BELOW: thr = in_ch.sample < $signed(cfg.threshold_low);
      gfte_pkg::CMP_ABOVE: thr = in_ch.sample > $signed(cfg.threshold_low);
      default:             thr = (in_ch.sample >= $signed(cfg.threshold_low)) &&
                                 (in_ch.sample <= $signed(cfg.threshold_high));
    endcase
  end

  always_comb begin
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = s1_adv & s1_ok_r;
      ram_waddr = s1_addr_r;
      ram_wdata = flag_new;
    end
  end

  gfte_ram #(
    .WIDTH (1),
    .DEPTH (NUM_GATES)
  ) u_flag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc_in),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign flag_old = s1_ok_r & (fwd_hit_r ? fwd_val_r : ram_rdata);

  gfte_edit u_edit (
    .cfg        (cfg),
    .sample     (s1_sample_r),
    .bnd        (s1_bnd_r),
    .miss       (s1_miss_r),
    .thr        (s1_thr_r),
    .flag_old   (flag_old),
    .sample_new (sample_new),
    .flag_new   (flag_new)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(NUM_GATES - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (acc_in) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1_gate_r   <= in_ch.gate;
      s1_sample_r <= in_ch.sample;
      s1_bnd_r    <= in_ch.in_boundary;
      s1_ok_r     <= gate_ok;
      s1_miss_r   <= miss;
      s1_thr_r    <= thr;
      s1_addr_r   <= raddr;
      // catch a write-back landing on the gate read at this edge
      fwd_hit_r   <= ram_we & (ram_waddr == raddr);
      fwd_val_r   <= ram_wdata;
    end
    if (s1_adv) begin
      out_gate_r   <= s1_gate_r;
      out_sample_r <= sample_new;
      out_flag_r   <= flag_new;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.gate_out   = out_gate_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.flag_out   = out_flag_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !acc_in)
    else $error("item accepted during flag clear");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_valid_r && !out_valid_r))
    else $error("item in flight during flag clear");

  a_fwd_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && ram_we && (ram_waddr == raddr)) |=> fwd_hit_r)
    else $error("colliding write-back not forwarded");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_gate_r)))
    else $error("stalled stage lost its item");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && !clr_busy_r) |-> (s1_valid_r && s1_ok_r))
    else $error("flag write without a valid in-range item");

endmodule

/* tb/sv/gfte_edit_checker.sv */
module gfte_edit_checker #(
  parameter int NUM_GATES = gfte_pkg::NUM_GATES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gfte_in_if                              in_mon,
  gfte_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [gfte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfte_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);

  typedef struct packed {
    logic [gfte_pkg::GATE_W-1:0]          gate;
    logic signed [gfte_pkg::SAMPLE_W-1:0] sample;
    logic                                 flag;
  } gate_result_t;

  gfte_pkg::cfg_t regs;
  bit             flag_mem [NUM_GATES];
  gate_result_t   expected_q [$];

  function automatic logic threshold_hit(logic signed [gfte_pkg::SAMPLE_W-1:0] s);
    case (regs.compare_mode)
      gfte_pkg::CMP_BELOW: return s < $signed(regs.threshold_low);
      gfte_pkg::CMP_ABOVE: return s > $signed(regs.threshold_low);
      // the spare mode behaves as between
      default: return s >= $signed(regs.threshold_low) &&
                      s <= $signed(regs.threshold_high);
    endcase
  endfunction

  function automatic gate_result_t edit_gate(logic [gfte_pkg::GATE_W-1:0] gate,
                                             logic signed [gfte_pkg::SAMPLE_W-1:0] sample,
                                             logic bnd);
    logic         mapped, f, m, t;
    gate_result_t r;
    mapped   = int'(gate) < NUM_GATES;
    f        = mapped ? flag_mem[gate] : 1'b0;
    m        = sample == $signed(regs.missing_code);
    t        = threshold_hit(sample);
    r.gate   = gate;
    r.sample = sample;
    case (regs.operation)
      gfte_pkg::OP_SET:   f = bnd && !m && t;
      gfte_pkg::OP_AND:   if (bnd) f = !m && f && t;
      gfte_pkg::OP_OR:    if (bnd && !m) f = f || t;
      gfte_pkg::OP_XOR:   if (bnd && !m) f = f ^ t;
      gfte_pkg::OP_COPY:  if (bnd) f = m;
      gfte_pkg::OP_CLEAR: f = 1'b0;
      gfte_pkg::OP_COMPL: f = !f;
      gfte_pkg::OP_ASSRT: if (bnd && f) r.sample = regs.missing_code;
      // sums and products keep the low 16 bits only
      gfte_pkg::OP_ADD:   if (bnd && f && !m) r.sample = sample + $signed(regs.add_amount);
      gfte_pkg::OP_MUL:   if (bnd && f && !m) r.sample = sample * $signed(regs.mul_amount);
      default: ;
    endcase
    if (mapped) flag_mem[gate] = f;
    r.flag = f;
    return r;
  endfunction

  task automatic report_field(string name, int exp_v, int act_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    gate_result_t want;
    if (!rst_n) begin
      regs = '{operation: gfte_pkg::OP_SET, compare_mode: gfte_pkg::CMP_BELOW,
               threshold_low: '0, threshold_high: '0,
               missing_code: gfte_pkg::MISSING_RST, add_amount: '0,
               mul_amount: gfte_pkg::MUL_AMT_RST};
      foreach (flag_mem[i]) flag_mem[i] = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gfte_pkg::REG_OPERATION: regs.operation      = cfg_data[gfte_pkg::OP_W-1:0];
          gfte_pkg::REG_CMP_MODE:  regs.compare_mode   = cfg_data[gfte_pkg::CMP_W-1:0];
          gfte_pkg::REG_THR_LOW:   regs.threshold_low  = cfg_data;
          gfte_pkg::REG_THR_HIGH:  regs.threshold_high = cfg_data;
          gfte_pkg::REG_MISSING:   regs.missing_code   = cfg_data;
          gfte_pkg::REG_ADD_AMT:   regs.add_amount     = cfg_data;
          gfte_pkg::REG_MUL_AMT:   regs.mul_amount     = cfg_data;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: expected no item, got gate %0d sample %0d flag %0b", $time,
                   out_mon.gate_out, out_mon.sample_out, out_mon.flag_out);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (out_mon.gate_out !== want.gate)
            report_field("gate_out", want.gate, out_mon.gate_out);
          if (out_mon.sample_out !== want.sample)
            report_field("sample_out", want.sample, out_mon.sample_out);
          if (out_mon.flag_out !== want.flag)
            report_field("flag_out", want.flag, out_mon.flag_out);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(edit_gate(in_mon.gate, in_mon.sample, in_mon.in_boundary));
    end
    pending = expected_q.size();
  end

endmodule

/* tb/sv/gate_flag_threshold_editor_core_tb.sv */
module gate_flag_threshold_editor_core_tb;

  localparam int GW  = gfte_pkg::GATE_W;
  localparam int SW  = gfte_pkg::SAMPLE_W;
  localparam int OPW = gfte_pkg::OP_W;
  localparam int CW  = gfte_pkg::CMP_W;
  localparam int IW  = gfte_pkg::CFG_IDX_W;
  localparam int DW  = gfte_pkg::CFG_DATA_W;

  // the flag sweep after reset is the longest quiet stretch
  localparam int STALL_LIMIT = 3 * gfte_pkg::NUM_GATES_DEF + 1000;

  localparam logic [OPW-1:0] OP_SPARE_LO = 4'd10;
  localparam logic [OPW-1:0] OP_SPARE_HI = 4'd15;
  localparam logic [CW-1:0]  CMP_SPARE   = 2'd3;
  localparam logic [IW-1:0]  REG_SPARE   = 3'd7;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  int fail_count, pending, checked;
  int items_sent, settings_used, quiet_cycles;
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;

  logic signed [SW-1:0] cur_low, cur_high, cur_missing;

  gfte_in_if  in_ch ();
  gfte_out_if out_ch ();

  gate_flag_threshold_editor_core #(
    .NUM_GATES(gfte_pkg::NUM_GATES_DEF)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  gfte_edit_checker #(
    .NUM_GATES(gfte_pkg::NUM_GATES_DEF)
  ) edit_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall bursts, solid ready once stalls are off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // hold the sender until every outstanding result is back
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_settings(logic [OPW-1:0] op, logic [CW-1:0] cmp,
                               logic [SW-1:0] lo, logic [SW-1:0] hi,
                               logic [SW-1:0] miss, logic [SW-1:0] add,
                               logic [SW-1:0] mul, logic [DW-1:0] junk);
    drain();
    write_reg(gfte_pkg::REG_OPERATION, {junk[DW-1:OPW], op});
    write_reg(gfte_pkg::REG_CMP_MODE, {junk[DW-1:CW], cmp});
    write_reg(gfte_pkg::REG_THR_LOW, lo);
    write_reg(gfte_pkg::REG_THR_HIGH, hi);
    write_reg(gfte_pkg::REG_MISSING, miss);
    write_reg(gfte_pkg::REG_ADD_AMT, add);
    write_reg(gfte_pkg::REG_MUL_AMT, mul);
    cur_low     = lo;
    cur_high    = hi;
    cur_missing = miss;
    settings_used++;
  endtask

  task automatic push_item(logic [GW-1:0] gate, logic [SW-1:0] sample, logic bnd);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.gate        = gate;
    in_ch.sample      = sample;
    in_ch.in_boundary = bnd;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic logic [SW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3:       return 16'hFFFF;
      4:       return SW'($urandom_range(0, 16) - 8);
      default: return SW'($urandom);
    endcase
  endfunction

  // mostly a small pool of gates so flags build up across settings
  function automatic logic [GW-1:0] pick_gate();
    case ($urandom_range(0, 9))
      0, 1:    return GW'($urandom);
      2:       return $urandom_range(0, 1) ? {GW{1'b1}} : {GW{1'b0}};
      default: return GW'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1:    return cur_missing;
      2:       return cur_low + SW'($urandom_range(0, 4) - 2);
      3:       return cur_high + SW'($urandom_range(0, 4) - 2);
      4:       return pick_word();
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic random_phase(bit edits_data, int count);
    logic [OPW-1:0] op;
    logic [CW-1:0]  cmp;
    logic [SW-1:0]  lo, hi, swap, mul;
    logic [DW-1:0]  junk;
    if (edits_data) begin
      op = OPW'($urandom_range(gfte_pkg::OP_ASSRT, gfte_pkg::OP_MUL));
    end else if ($urandom_range(0, 9) == 0) begin
      op = OPW'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end else begin
      op = OPW'($urandom_range(gfte_pkg::OP_SET, gfte_pkg::OP_COMPL));
    end
    cmp = CW'($urandom_range(gfte_pkg::CMP_BELOW, CMP_SPARE));
    lo  = pick_word();
    hi  = pick_word();
    if ($signed(lo) > $signed(hi) && $urandom_range(0, 3) != 0) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    mul  = $urandom_range(0, 1) ? SW'($urandom_range(0, 8) - 4) : pick_word();
    // upper bits of the narrow registers must be dropped
    junk = ($urandom_range(0, 3) == 0) ? DW'($urandom) : '0;
    load_settings(op, cmp, lo, hi, ($urandom_range(0, 2) == 0) ? cur_missing : pick_word(),
                  pick_word(), mul, junk);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, DW'($urandom));
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 && $urandom_range(0, 3) == 0) drain();
      push_item(pick_gate(), pick_sample(), $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.gate        = '0;
    in_ch.sample      = '0;
    in_ch.in_boundary = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // set from a below test; missing and out-of-boundary samples clear
    load_settings(gfte_pkg::OP_SET, gfte_pkg::CMP_BELOW, '0, '0, 16'h8000, '0, 16'd1, '0);
    write_reg(REG_SPARE, 16'hFFFF);
    push_item(11'd0, 16'h8000, 1'b1);
    push_item(11'h7FF, 16'hFFFF, 1'b1);
    push_item(11'd1, 16'h7FFF, 1'b1);
    push_item(11'd2, 16'hFFFE, 1'b0);
    push_item(11'd3, -16'sd100, 1'b1);

    load_settings(gfte_pkg::OP_AND, gfte_pkg::CMP_ABOVE, -16'sd200, '0, 16'h8000, '0,
                  16'd1, '0);
    push_item(11'h7FF, -16'sd300, 1'b1);
    push_item(11'd3, 16'sd50, 1'b1);
    push_item(11'd1, 16'h8000, 1'b1);

    load_settings(gfte_pkg::OP_OR, gfte_pkg::CMP_BETWEEN, -16'sd10, 16'sd10, 16'h8000, '0,
                  16'd1, '0);
    push_item(11'd1, 16'sd0, 1'b1);
    push_item(11'd2, 16'sd11, 1'b1);
    push_item(11'd2, 16'sd0, 1'b0);

    load_settings(gfte_pkg::OP_XOR, CMP_SPARE, -16'sd10, 16'sd10, 16'h8000, '0, 16'd1, '0);
    push_item(11'd1, 16'sd5, 1'b1);
    push_item(11'd0, -16'sd10, 1'b1);

    load_settings(gfte_pkg::OP_COPY, gfte_pkg::CMP_BELOW, '0, '0, 16'h7FFF, '0, 16'd1, '0);
    push_item(11'd0, 16'h7FFF, 1'b1);
    push_item(11'd1, 16'sd7, 1'b1);
    push_item(11'd3, 16'h7FFF, 1'b0);

    load_settings(gfte_pkg::OP_COMPL, gfte_pkg::CMP_BELOW, '0, '0, 16'h7FFF, '0, 16'd1, '0);
    push_item(11'd3, 16'sd0, 1'b0);
    push_item(11'd4, 16'sd0, 1'b1);

    load_settings(gfte_pkg::OP_ASSRT, gfte_pkg::CMP_BELOW, '0, '0, 16'h1234, '0, 16'd1, '0);
    push_item(11'd4, 16'sd99, 1'b1);
    push_item(11'd0, 16'sd5, 1'b0);

    // add wraps past the top; the missing code is left alone
    load_settings(gfte_pkg::OP_ADD, gfte_pkg::CMP_BELOW, '0, '0, 16'h1234, 16'h7FFF,
                  16'd1, '0);
    push_item(11'd4, 16'sd1, 1'b1);
    push_item(11'd4, 16'h1234, 1'b1);

    load_settings(gfte_pkg::OP_MUL, gfte_pkg::CMP_BELOW, '0, '0, 16'h1234, '0,
                  16'h8000, '0);
    push_item(11'd4, 16'sd3, 1'b1);

    load_settings(gfte_pkg::OP_CLEAR, gfte_pkg::CMP_BELOW, '0, '0, 16'h1234, '0, 16'd1, '0);
    push_item(11'd4, 16'sd0, 1'b0);

    load_settings(OP_SPARE_LO, gfte_pkg::CMP_BELOW, '0, '0, 16'h1234, '0, 16'd1, '0);
    push_item(11'd0, 16'sd1, 1'b1);
    load_settings(OP_SPARE_HI, gfte_pkg::CMP_BELOW, '0, '0, 16'h1234, '0, 16'd1, '0);
    push_item(11'd1, 16'sd2, 1'b1);

    // alternate flag-building and sample-editing settings; last two run flat out
    for (int p = 0; p < 16; p++) begin
      gaps_on   = p < 14;
      stalls_on = p < 14;
      random_phase(p % 2 == 1, $urandom_range(38, 52));
    end

    drain();
    repeat (4) @(negedge clk);
    $display("covered %0d items under %0d register settings, all operations and modes",
             items_sent, settings_used);
    $display("%0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/gfte_pkg.sv
src/gfte_if.sv
src/gfte_ram.sv
src/gfte_cfg.sv
src/gfte_edit.sv
src/gate_flag_threshold_editor_core.sv
tb/sv/gfte_edit_checker.sv
tb/sv/gate_flag_threshold_editor_core_tb.sv
